FILE: rtl/core/hssd_pkg.sv
// Shared types, codes and segment tables for the hex status display core.
`timescale 1ns / 1ps
`default_nettype none

package hssd_pkg;

   // Command codes.
   localparam logic [1:0] OP_CHECKSUM = 2'd0;
   localparam logic [1:0] OP_BUSY     = 2'd1;
   localparam logic [1:0] OP_ERROR    = 2'd2;
   localparam logic [1:0] OP_CLEAR    = 2'd3;

   // Display port codes.
   localparam logic [2:0] PORT_SLOT       = 3'd0;
   localparam logic [2:0] PORT_LEFT_HIGH  = 3'd1;
   localparam logic [2:0] PORT_LEFT_LOW   = 3'd2;
   localparam logic [2:0] PORT_RIGHT_HIGH = 3'd3;
   localparam logic [2:0] PORT_RIGHT_LOW  = 3'd4;

   // Fixed active-low segment words.
   localparam logic [15:0] WORD_BLANK     = 16'hffff;
   localparam logic [15:0] WORD_DOTS      = 16'hdfdf;
   localparam logic [15:0] WORD_E_DOT_EVN = 16'he0df;
   localparam logic [15:0] WORD_E_DOT_ODD = 16'hdfe0;
   localparam logic [15:0] SHADOW_RESET   = 16'hffff;

   // Most port writes that one command causes.
   localparam int unsigned RESULTS_MAX = 3;

   // Formatted transaction handed from the formatter to the result sequencer.
   typedef struct packed {
      logic        clear;
      logic [15:0] shadow;
      logic [15:0] hi_word;
      logic [15:0] lo_word;
   } burst_type;

   // Active-low segment pattern of one hex digit.
   function automatic logic [7:0] seg_pattern(input logic [3:0] nibble);
      logic [7:0] pat;
      case (nibble)
         4'h0:    pat = 8'h24;
         4'h1:    pat = 8'h3f;
         4'h2:    pat = 8'h62;
         4'h3:    pat = 8'h2a;
         4'h4:    pat = 8'h39;
         4'h5:    pat = 8'ha8;
         4'h6:    pat = 8'ha0;
         4'h7:    pat = 8'h3c;
         4'h8:    pat = 8'h20;
         4'h9:    pat = 8'h28;
         4'ha:    pat = 8'h30;
         4'hb:    pat = 8'ha1;
         4'hc:    pat = 8'he4;
         4'hd:    pat = 8'h23;
         4'he:    pat = 8'he0;
         default: pat = 8'hf0;
      endcase
      return pat;
   endfunction

   // Two digits as one word; the bytes are swapped for the right pair.
   function automatic logic [15:0] pair_word(input logic [3:0] hi_nib,
                                             input logic [3:0] lo_nib,
                                             input logic       odd);
      logic [7:0] h;
      logic [7:0] l;
      h = seg_pattern(hi_nib);
      l = seg_pattern(lo_nib);
      return odd ? {l, h} : {h, l};
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/hex_seven_segment_status_display_core.sv
// Top level of the hex seven-segment status display core.
// A taken command is held in the command register, then loaded into the result register, from
// which its first result is offered; a command waiting on a busy sequencer adds that wait.
// Each command gives three display words (two for clear) on the single result port, which
// carries one display word per cycle while not stalled; a one-entry command register takes the
// next command while the current words drain.
// Reset: synchronous; empties both registers and sets the slot shadow to all segments off.
`timescale 1ns / 1ps
`default_nettype none

module hex_seven_segment_status_display_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_op,
   input  wire logic [3:0]  req_slot,
   input  wire logic [15:0] req_value,
   input  wire logic        req_dot_on,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_port_select,
   output logic [15:0]      rsp_port_word,
   output logic             rsp_last
);
   import hssd_pkg::*;

   localparam int unsigned IDX_W = $clog2(RESULTS_MAX);
   localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(RESULTS_MAX - 1);
   localparam logic [IDX_W-1:0] IDX_FIRST = '0;
   localparam logic [IDX_W-1:0] IDX_HIGH  = IDX_W'(RESULTS_MAX - 2);

   // Command input register.
   logic        cmd_valid_ff, cmd_valid_in;
   logic [1:0]  cmd_op_ff;
   logic [3:0]  cmd_slot_ff;
   logic [15:0] cmd_value_ff;
   logic        cmd_dot_on_ff;

   // Result register: one burst of display words.
   logic              busy_ff, busy_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              odd_ff;
   logic [15:0]       shadow_ff, shadow_in;
   logic [15:0]       hi_word_ff;
   logic [15:0]       lo_word_ff;

   burst_type burst;
   logic      req_take;
   logic      rsp_take;
   logic      load;

   hssd_format u_format (
      .op     (cmd_op_ff),
      .slot   (cmd_slot_ff),
      .value  (cmd_value_ff),
      .dot_on (cmd_dot_on_ff),
      .shadow (shadow_ff),
      .burst  (burst)
   );

   // Handshake decode.
   assign req_stall = cmd_valid_ff;
   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = rsp_valid && !rsp_stall;
   assign load      = cmd_valid_ff && (!busy_ff || (rsp_take && rsp_last));

   // Next state of the command register and the result sequencer.
   always_comb begin
      cmd_valid_in = cmd_valid_ff;
      if (load) begin
         cmd_valid_in = 1'b0;
      end
      if (req_take) begin
         cmd_valid_in = 1'b1;
      end

      busy_in   = busy_ff;
      idx_in    = idx_ff;
      shadow_in = shadow_ff;
      if (rsp_take) begin
         if (rsp_last) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + IDX_W'(1);
         end
      end
      if (load) begin
         busy_in   = 1'b1;
         idx_in    = burst.clear ? IDX_HIGH : IDX_FIRST;
         shadow_in = burst.shadow;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_valid_ff <= 1'b0;
         busy_ff      <= 1'b0;
         idx_ff       <= IDX_FIRST;
         shadow_ff    <= SHADOW_RESET;
      end else begin
         cmd_valid_ff <= cmd_valid_in;
         busy_ff      <= busy_in;
         idx_ff       <= idx_in;
         shadow_ff    <= shadow_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_take) begin
         cmd_op_ff     <= req_op;
         cmd_slot_ff   <= req_slot;
         cmd_value_ff  <= req_value;
         cmd_dot_on_ff <= req_dot_on;
      end
      if (load) begin
         odd_ff     <= cmd_slot_ff[0];
         hi_word_ff <= burst.hi_word;
         lo_word_ff <= burst.lo_word;
      end
   end

   // Result transaction select.
   always_comb begin
      rsp_valid = busy_ff;
      rsp_last  = (idx_ff == IDX_LAST);
      case (idx_ff)
         IDX_FIRST: begin
            rsp_port_select = PORT_SLOT;
            rsp_port_word   = shadow_ff;
         end
         IDX_HIGH: begin
            rsp_port_select = odd_ff ? PORT_RIGHT_HIGH : PORT_LEFT_HIGH;
            rsp_port_word   = hi_word_ff;
         end
         default: begin
            rsp_port_select = odd_ff ? PORT_RIGHT_LOW : PORT_LEFT_LOW;
            rsp_port_word   = lo_word_ff;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: rtl/core/hssd_format.sv
// Combinational formatter: turns one command into its display words.
`timescale 1ns / 1ps
`default_nettype none

module hssd_format (
   input  wire logic [1:0]        op,
   input  wire logic [3:0]        slot,
   input  wire logic [15:0]       value,
   input  wire logic              dot_on,
   input  wire logic [15:0]       shadow,
   output hssd_pkg::burst_type    burst
);
   import hssd_pkg::*;

   logic       odd;
   logic [7:0] slot_pat;

   assign odd      = slot[0];
   assign slot_pat = seg_pattern(slot);

   // Merge the slot digit into the shadow (except for clear) and pick the pair words.
   always_comb begin
      burst.clear  = (op == OP_CLEAR);
      burst.shadow = shadow;
      if (op != OP_CLEAR) begin
         burst.shadow = odd ? {slot_pat, shadow[7:0]} : {shadow[15:8], slot_pat};
      end
      case (op)
         OP_CHECKSUM: begin
            burst.hi_word = pair_word(value[15:12], value[11:8], odd);
            burst.lo_word = pair_word(value[7:4], value[3:0], odd);
         end
         OP_BUSY: begin
            burst.hi_word = dot_on ? WORD_DOTS : WORD_BLANK;
            burst.lo_word = dot_on ? WORD_DOTS : WORD_BLANK;
         end
         OP_ERROR: begin
            burst.hi_word = odd ? WORD_E_DOT_ODD : WORD_E_DOT_EVN;
            burst.lo_word = pair_word(value[7:4], value[3:0], odd);
         end
         default: begin
            burst.hi_word = WORD_BLANK;
            burst.lo_word = WORD_BLANK;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: rtl/core/hssd_checker.sv
// Port-level checker for the hex status display core, with its bind.
`timescale 1ns / 1ps
`default_nettype none

module hssd_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [2:0]  rsp_port_select,
   input wire logic [15:0] rsp_port_word,
   input wire logic        rsp_last
);
   import hssd_pkg::*;

   // No result transaction is offered right after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered after reset");

   // A stalled result transaction holds its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_port_select)
         && $stable(rsp_port_word) && $stable(rsp_last))
      else $error("stalled result changed");

   // The slot-number port write never ends a command.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_port_select == PORT_SLOT |-> !rsp_last)
      else $error("slot port write marked last");

   // The final write of a command always goes to a low word.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |->
         rsp_port_select == PORT_LEFT_LOW || rsp_port_select == PORT_RIGHT_LOW)
      else $error("last write not to a low word");

   // A taken command fills the input register, which stalls the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input register did not hold the command");

endmodule

bind hex_seven_segment_status_display_core hssd_checker u_hssd_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_port_select (rsp_port_select),
   .rsp_port_word   (rsp_port_word),
   .rsp_last        (rsp_last)
);

`default_nettype wire
